@@ rtl/jpeg_sof3_marker_checker_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the SOF3 marker checker
// Concurrent checks clocked on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef JPEG_SOF3_MARKER_CHECKER_ASSERT_SVH
`define JPEG_SOF3_MARKER_CHECKER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define SOF3C_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
// Next-cycle implication.
`define SOF3C_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define SOF3C_ASSERT_NOW(label, pre, post, msg)
`define SOF3C_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

@@ rtl/sof3c_pkg.sv @@
// ----------------------------------------------------------------------------
// SOF3 marker checker package
// Shared types, status codes and marker constants.
// ----------------------------------------------------------------------------
package sof3c_pkg;

	typedef logic [1:0] status_t;

	localparam status_t ST_VALID       = 2'd0;
	localparam status_t ST_MALFORMED   = 2'd1;
	localparam status_t ST_UNSUPPORTED = 2'd2;
	localparam status_t ST_TRUNCATED   = 2'd3;

	typedef logic cfg_index_t;
	localparam cfg_index_t CFG_WIDTH  = 1'b0;
	localparam cfg_index_t CFG_HEIGHT = 1'b1;

	localparam logic [7:0] MK_FILL = 8'hff;
	localparam logic [7:0] MK_SOI  = 8'hd8;
	localparam logic [7:0] MK_EOI  = 8'hd9;
	localparam logic [7:0] MK_SOS  = 8'hda;
	localparam logic [7:0] MK_SOF3 = 8'hc3;
	localparam logic [7:0] MK_DHT  = 8'hc4;
	localparam logic [7:0] MK_JPG  = 8'hc8;
	localparam logic [7:0] MK_DAC  = 8'hcc;
	localparam logic [7:0] MK_SOF0 = 8'hc0;
	localparam logic [7:0] MK_SOF15 = 8'hcf;
	localparam logic [7:0] MK_RST0 = 8'hd0;
	localparam logic [7:0] MK_RST7 = 8'hd7;
	localparam logic [7:0] MK_TEM  = 8'h01;
	localparam logic [7:0] MK_NONE = 8'h00;

	localparam logic [15:0] FRAME_LEN     = 16'd11;
	localparam logic [7:0]  PRECISION     = 8'd16;
	localparam logic [7:0]  NUM_COMP      = 8'd1;
	localparam logic [7:0]  SAMPLING      = 8'h11;
	localparam logic [7:0]  QUANT_TABLE   = 8'h00;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} item_t;

	function automatic logic is_frame_marker(input logic [7:0] m);
		return (m >= MK_SOF0) && (m <= MK_SOF15) && (m != MK_DHT) && (m != MK_JPG)
			&& (m != MK_DAC);
	endfunction

	function automatic logic is_bad_marker(input logic [7:0] m);
		return (m == MK_NONE) || (m == MK_TEM) || (m == MK_SOI)
			|| ((m >= MK_RST0) && (m <= MK_RST7));
	endfunction

endpackage

@@ rtl/sof3c_if.sv @@
// ----------------------------------------------------------------------------
// SOF3 marker checker channels
// Byte stream channel in, status channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface sof3c_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface sof3c_result_if;
	logic                 valid;
	logic                 ready;
	sof3c_pkg::status_t   status;

	modport source (output valid, output status, input ready);
	modport sink   (input valid, input status, output ready);
endinterface

@@ rtl/sof3c_in_reg.sv @@
// ----------------------------------------------------------------------------
// Input register
// Holds one stream word and releases it when the result side has room.
// ----------------------------------------------------------------------------
module sof3c_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	sof3c_stream_if.sink       stream,
	input  logic               out_free,
	output sof3c_pkg::item_t   item,
	output logic               step_en
);
	import sof3c_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	assign step_en      = valid_s1 & out_free;
	assign stream.ready = ~valid_s1 | step_en;
	assign item         = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			item_s1 <= '{data_byte: stream.data_byte, final_byte: stream.final_byte};
		end
	end

endmodule

@@ rtl/sof3c_parser.sv @@
// ----------------------------------------------------------------------------
// Marker segment parser
// One byte per step: start marker, fill bytes, lengths, frame header fields.
// ----------------------------------------------------------------------------
`include "jpeg_sof3_marker_checker_assert.svh"

module sof3c_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  sof3c_pkg::item_t   item,
	input  logic [15:0]        expected_width,
	input  logic [15:0]        expected_height,
	output logic               res_load,
	output sof3c_pkg::status_t status
);
	import sof3c_pkg::*;

	typedef enum logic [3:0] {
		PH_START0 = 4'd0,
		PH_START1 = 4'd1,
		PH_MARK   = 4'd2,
		PH_FILL   = 4'd3,
		PH_LEN_HI = 4'd4,
		PH_LEN_LO = 4'd5,
		PH_BODY   = 4'd6
	} phase_t;

	// frame header body offsets
	localparam logic [3:0] HO_PREC  = 4'd0;
	localparam logic [3:0] HO_H_HI  = 4'd1;
	localparam logic [3:0] HO_H_LO  = 4'd2;
	localparam logic [3:0] HO_W_HI  = 4'd3;
	localparam logic [3:0] HO_W_LO  = 4'd4;
	localparam logic [3:0] HO_NCOMP = 4'd5;
	localparam logic [3:0] HO_SAMP  = 4'd7;
	localparam logic [3:0] HO_QT    = 4'd8;
	localparam logic [3:0] HO_MAX   = 4'd15;

	phase_t      phase_q, phase_n;
	logic [2:0]  bytes_seen_q, bytes_seen_n;
	logic [7:0]  marker_q, marker_n;
	logic [7:0]  length_high_q, length_high_n;
	logic [15:0] segment_left_q, segment_left_n;
	logic [3:0]  header_offset_q, header_offset_n;
	logic        frame_found_q, frame_found_n;
	logic        frame_bad_q, frame_bad_n;
	logic [7:0]  held_byte_q, held_byte_n;
	logic        decided_q, decided_n;

	logic        hit;
	status_t     code;
	logic [15:0] size;
	logic [15:0] left_m2;
	logic [7:0]  b;
	logic        fin;

	assign b       = item.data_byte;
	assign fin     = item.final_byte;
	assign size    = {length_high_q, b};
	assign left_m2 = size - 16'd2;

	always_comb begin
		phase_n         = phase_q;
		bytes_seen_n    = bytes_seen_q;
		marker_n        = marker_q;
		length_high_n   = length_high_q;
		segment_left_n  = segment_left_q;
		header_offset_n = header_offset_q;
		frame_found_n   = frame_found_q;
		frame_bad_n     = frame_bad_q;
		held_byte_n     = held_byte_q;
		decided_n       = decided_q;
		hit             = 1'b0;
		code            = ST_MALFORMED;

		if (!decided_q) begin
			if (bytes_seen_q != 3'd7) begin
				bytes_seen_n = bytes_seen_q + 3'd1;
			end
			unique case (phase_q)
				PH_START0: begin
					if (b != MK_FILL) hit = 1'b1;
					else phase_n = PH_START1;
				end
				PH_START1: begin
					if (b != MK_SOI) hit = 1'b1;
					else phase_n = PH_MARK;
				end
				PH_MARK: begin
					if (b != MK_FILL) hit = 1'b1;
					else phase_n = PH_FILL;
				end
				PH_FILL: begin
					// skip fill bytes
					if (b != MK_FILL) begin
						marker_n = b;
						if (b == MK_SOS) begin
							hit  = 1'b1;
							code = frame_found_q ? ST_VALID : ST_UNSUPPORTED;
						end else if (b == MK_EOI) begin
							hit  = 1'b1;
							code = ST_TRUNCATED;
						end else if (is_bad_marker(b)) begin
							hit = 1'b1;
						end else begin
							phase_n         = PH_LEN_HI;
							frame_bad_n     = 1'b0;
							header_offset_n = '0;
						end
					end
				end
				PH_LEN_HI: begin
					length_high_n = b;
					phase_n       = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					if (size < 16'd2) begin
						hit = 1'b1;
					end else begin
						segment_left_n = left_m2;
						if (is_frame_marker(marker_q) &&
						    (marker_q != MK_SOF3 || frame_found_q || size != FRAME_LEN)) begin
							frame_bad_n = 1'b1;
						end
						if (left_m2 == '0) begin
							phase_n = PH_MARK;
							if (frame_bad_n) begin
								hit  = 1'b1;
								code = ST_UNSUPPORTED;
							end else if (marker_q == MK_SOF3) begin
								frame_found_n = 1'b1;
							end
						end else begin
							phase_n = PH_BODY;
						end
					end
				end
				PH_BODY: begin
					if (marker_q == MK_SOF3 && !frame_bad_q) begin
						unique case (header_offset_q)
							HO_PREC:  if (b != PRECISION) frame_bad_n = 1'b1;
							HO_H_HI:  held_byte_n = b;
							HO_H_LO:  if ({held_byte_q, b} != expected_height) frame_bad_n = 1'b1;
							HO_W_HI:  held_byte_n = b;
							HO_W_LO:  if ({held_byte_q, b} != expected_width) frame_bad_n = 1'b1;
							HO_NCOMP: if (b != NUM_COMP) frame_bad_n = 1'b1;
							HO_SAMP:  if (b != SAMPLING) frame_bad_n = 1'b1;
							HO_QT:    if (b != QUANT_TABLE) frame_bad_n = 1'b1;
							default: ;
						endcase
					end
					if (header_offset_q != HO_MAX) begin
						header_offset_n = header_offset_q + 4'd1;
					end
					if (segment_left_q != '0) begin
						segment_left_n = segment_left_q - 16'd1;
					end
					if (segment_left_n == '0) begin
						phase_n = PH_MARK;
						if (frame_bad_n) begin
							hit  = 1'b1;
							code = ST_UNSUPPORTED;
						end else if (marker_q == MK_SOF3) begin
							frame_found_n = 1'b1;
						end
					end
				end
				default: hit = 1'b1;
			endcase

			// final word overrides: short stream, then truncation
			if (fin && bytes_seen_n < 3'd4) begin
				hit  = 1'b1;
				code = ST_MALFORMED;
			end else if (fin && !hit) begin
				hit  = 1'b1;
				code = ST_TRUNCATED;
			end
			if (hit && !fin) begin
				decided_n = 1'b1;
			end
		end

		// re-arm for the next stream
		if (fin) begin
			phase_n         = PH_START0;
			bytes_seen_n    = '0;
			marker_n        = '0;
			length_high_n   = '0;
			segment_left_n  = '0;
			header_offset_n = '0;
			frame_found_n   = 1'b0;
			frame_bad_n     = 1'b0;
			held_byte_n     = '0;
			decided_n       = 1'b0;
		end
	end

	assign res_load = step_en & hit;
	assign status   = code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_START0;
			bytes_seen_q    <= '0;
			marker_q        <= '0;
			length_high_q   <= '0;
			segment_left_q  <= '0;
			header_offset_q <= '0;
			frame_found_q   <= 1'b0;
			frame_bad_q     <= 1'b0;
			held_byte_q     <= '0;
			decided_q       <= 1'b0;
		end else if (step_en) begin
			phase_q         <= phase_n;
			bytes_seen_q    <= bytes_seen_n;
			marker_q        <= marker_n;
			length_high_q   <= length_high_n;
			segment_left_q  <= segment_left_n;
			header_offset_q <= header_offset_n;
			frame_found_q   <= frame_found_n;
			frame_bad_q     <= frame_bad_n;
			held_byte_q     <= held_byte_n;
			decided_q       <= decided_n;
		end
	end

	`SOF3C_ASSERT_NOW(a_decided_silent, step_en && decided_q, !res_load, "result after decision")
	`SOF3C_ASSERT_NEXT(a_final_rearms, step_en && fin, !decided_q && phase_q == PH_START0, "final word did not re-arm")
	`SOF3C_ASSERT_NEXT(a_result_decides, res_load && !fin, decided_q, "result without decision")
	`SOF3C_ASSERT_NOW(a_body_left, phase_q == PH_BODY, segment_left_q != '0, "body with nothing left")

endmodule

@@ rtl/sof3c_out_reg.sv @@
// ----------------------------------------------------------------------------
// Output register
// Holds one status word until the sink takes it.
// ----------------------------------------------------------------------------
module sof3c_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  sof3c_pkg::status_t status_in,
	sof3c_result_if.source     result,
	output logic               free
);
	import sof3c_pkg::*;

	logic    valid_q;
	status_t status_q;

	assign free          = ~valid_q | result.ready;
	assign result.valid  = valid_q;
	assign result.status = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= status_in;
		end
	end

endmodule

@@ rtl/jpeg_sof3_marker_checker.sv @@
// ----------------------------------------------------------------------------
// JPEG SOF3 marker checker
// Walks a JPEG byte stream and reports one status word per stream.
//
//  channel   dir  payload                      handshake
//  stream    in   data_byte[7:0], final_byte   valid / ready
//  result    out  status[1:0]                  valid / ready
//  cfg       in   cfg_index, cfg_data[15:0]    cfg_we, no ready
//
//  One byte per cycle while the output register is free: a byte waits in the
//  input register, the parser updates its state and, if the byte decides,
//  loads the output register; status is valid once that register holds it.
//  A held status word stalls the parser for every byte, deciding or not;
//  the input register then takes at most one more word.
//  Reset clears the parser state, both handshake registers and the config.
// ----------------------------------------------------------------------------
module jpeg_sof3_marker_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	sof3c_stream_if.sink          stream,
	sof3c_result_if.source        result,
	input  logic                  cfg_we,
	input  sof3c_pkg::cfg_index_t cfg_index,
	input  logic [15:0]           cfg_data
);
	import sof3c_pkg::*;

	logic [15:0] expected_width_q;
	logic [15:0] expected_height_q;
	item_t       item;
	logic        step_en;
	logic        out_free;
	logic        res_load;
	status_t     res_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_width_q  <= '0;
			expected_height_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH:  expected_width_q  <= cfg_data;
				CFG_HEIGHT: expected_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sof3c_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.out_free (out_free),
		.item     (item),
		.step_en  (step_en)
	);

	sof3c_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.step_en         (step_en),
		.item            (item),
		.expected_width  (expected_width_q),
		.expected_height (expected_height_q),
		.res_load        (res_load),
		.status          (res_status)
	);

	sof3c_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.status_in (res_status),
		.result    (result),
		.free      (out_free)
	);

endmodule

@@ tb/sv/jpeg_sof3_marker_checker_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JPEG SOF3 marker checker testbench
// Feeds byte streams into the checker and compares each status word with a
// cycle-free parser model kept in step with every accepted byte. A few short
// hand-made streams come first. Random streams follow under several width and
// height settings: mostly well-formed marker walks with random segments and
// frame headers, plus corrupted, cut-off and noise streams. Both channels idle
// at random.
// ----------------------------------------------------------------------------
module jpeg_sof3_marker_checker_tb;
	import sof3c_pkg::*;

	typedef enum logic [3:0] {
		PH_SOI_FF,
		PH_SOI_ID,
		PH_MARK_FF,
		PH_MARK_ID,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_BODY
	} parse_phase_t;

	// frame header body offsets
	localparam logic [3:0] OFS_PRECISION = 4'd0;
	localparam logic [3:0] OFS_HEIGHT_HI = 4'd1;
	localparam logic [3:0] OFS_HEIGHT_LO = 4'd2;
	localparam logic [3:0] OFS_WIDTH_HI  = 4'd3;
	localparam logic [3:0] OFS_WIDTH_LO  = 4'd4;
	localparam logic [3:0] OFS_NCOMP     = 4'd5;
	localparam logic [3:0] OFS_SAMPLING  = 4'd7;
	localparam logic [3:0] OFS_QTABLE    = 4'd8;

	localparam logic [7:0] MK_APP0 = 8'he0;
	localparam logic [7:0] MK_DQT  = 8'hdb;
	localparam logic [7:0] MK_DRI  = 8'hdd;
	localparam logic [7:0] MK_COM  = 8'hfe;

	bit          clk;
	logic        arst_n;
	logic        cfg_we;
	cfg_index_t  cfg_index;
	logic [15:0] cfg_data;

	sof3c_stream_if stream_bus();
	sof3c_result_if result_bus();

	jpeg_sof3_marker_checker u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (stream_bus),
		.result    (result_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// parser model state
	parse_phase_t pm_phase;
	logic [2:0]   pm_count;
	logic [7:0]   pm_marker;
	logic [7:0]   pm_len_hi;
	logic [15:0]  pm_left;
	logic [3:0]   pm_offset;
	logic         pm_found;
	logic         pm_bad;
	logic [7:0]   pm_held;
	logic         pm_decided;
	logic [15:0]  pm_width;
	logic [15:0]  pm_height;

	status_t     pending_status[$];
	logic [7:0]  pkt[$];
	int          sent_bytes;
	int          error_count;
	int          burst_left;
	bit          idle_on;
	int          rx_mode;
	int          rx_left;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic sof_code(input logic [7:0] m);
		return m >= MK_SOF0 && m <= MK_SOF15 && m != MK_DHT && m != MK_JPG && m != MK_DAC;
	endfunction

	function automatic void clear_parser();
		pm_phase   = PH_SOI_FF;
		pm_count   = '0;
		pm_marker  = '0;
		pm_len_hi  = '0;
		pm_left    = '0;
		pm_offset  = '0;
		pm_found   = 1'b0;
		pm_bad     = 1'b0;
		pm_held    = '0;
		pm_decided = 1'b0;
	endfunction

	task automatic close_segment(inout logic hit, inout status_t st);
		pm_phase = PH_MARK_FF;
		if (pm_bad) begin
			hit = 1'b1;
			st  = ST_UNSUPPORTED;
		end else if (pm_marker == MK_SOF3) begin
			pm_found = 1'b1;
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic last, output logic hit,
			output status_t st);
		logic [15:0] size;
		hit  = 1'b0;
		st   = ST_VALID;
		if (pm_decided) begin
			if (last)
				clear_parser();
		end else begin
			if (pm_count < 3'd7)
				pm_count++;
			case (pm_phase)
				PH_SOI_FF: begin
					if (b != MK_FILL) begin
						hit = 1'b1;
						st  = ST_MALFORMED;
					end else begin
						pm_phase = PH_SOI_ID;
					end
				end
				PH_SOI_ID: begin
					if (b != MK_SOI) begin
						hit = 1'b1;
						st  = ST_MALFORMED;
					end else begin
						pm_phase = PH_MARK_FF;
					end
				end
				PH_MARK_FF: begin
					if (b != MK_FILL) begin
						hit = 1'b1;
						st  = ST_MALFORMED;
					end else begin
						pm_phase = PH_MARK_ID;
					end
				end
				PH_MARK_ID: begin
					// fill bytes keep us here
					if (b != MK_FILL) begin
						pm_marker = b;
						if (b == MK_SOS) begin
							hit = 1'b1;
							st  = pm_found ? ST_VALID : ST_UNSUPPORTED;
						end else if (b == MK_EOI) begin
							hit = 1'b1;
							st  = ST_TRUNCATED;
						end else if (b == MK_NONE || b == MK_TEM || b == MK_SOI
								|| (b >= MK_RST0 && b <= MK_RST7)) begin
							hit = 1'b1;
							st  = ST_MALFORMED;
						end else begin
							pm_phase  = PH_LEN_HI;
							pm_bad    = 1'b0;
							pm_offset = '0;
						end
					end
				end
				PH_LEN_HI: begin
					pm_len_hi = b;
					pm_phase  = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					size = {pm_len_hi, b};
					if (size < 16'd2) begin
						hit = 1'b1;
						st  = ST_MALFORMED;
					end else begin
						pm_left = size - 16'd2;
						if (sof_code(pm_marker)
								&& (pm_marker != MK_SOF3 || pm_found || size != FRAME_LEN))
							pm_bad = 1'b1;
						if (pm_left == '0)
							close_segment(hit, st);
						else
							pm_phase = PH_BODY;
					end
				end
				PH_BODY: begin
					if (pm_marker == MK_SOF3 && !pm_bad) begin
						case (pm_offset)
							OFS_PRECISION: if (b != PRECISION) pm_bad = 1'b1;
							OFS_HEIGHT_HI: pm_held = b;
							OFS_HEIGHT_LO: if ({pm_held, b} != pm_height) pm_bad = 1'b1;
							OFS_WIDTH_HI:  pm_held = b;
							OFS_WIDTH_LO:  if ({pm_held, b} != pm_width) pm_bad = 1'b1;
							OFS_NCOMP:     if (b != NUM_COMP) pm_bad = 1'b1;
							OFS_SAMPLING:  if (b != SAMPLING) pm_bad = 1'b1;
							OFS_QTABLE:    if (b != QUANT_TABLE) pm_bad = 1'b1;
							default: ;
						endcase
					end
					if (pm_offset < 4'd15)
						pm_offset++;
					if (pm_left != '0)
						pm_left--;
					if (pm_left == '0)
						close_segment(hit, st);
				end
				default: begin
					hit = 1'b1;
					st  = ST_MALFORMED;
				end
			endcase
			if (last && pm_count < 3'd4) begin
				hit = 1'b1;
				st  = ST_MALFORMED;
			end else if (last && !hit) begin
				hit = 1'b1;
				st  = ST_TRUNCATED;
			end
			if (hit) begin
				if (last)
					clear_parser();
				else
					pm_decided = 1'b1;
			end
		end
	endtask

	// receiver: switch at random between stall patterns
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		case (rx_mode)
			0:       result_bus.ready <= 1'b1;
			1:       result_bus.ready <= 1'($urandom_range(0, 1));
			2:       result_bus.ready <= ($urandom_range(0, 3) == 0);
			default: result_bus.ready <= (rx_left % 16 == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_status.size() == 0) begin
				$error("status word %0d with none expected", result_bus.status);
				error_count++;
			end else if (result_bus.status !== pending_status[0]) begin
				$error("status mismatch: expected %0d, actual %0d",
					pending_status[0], result_bus.status);
				error_count++;
				void'(pending_status.pop_front());
			end else begin
				void'(pending_status.pop_front());
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int      gap;
		logic    hit;
		status_t st;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (idle_on) begin
				gap = $urandom_range(1, 6);
				@(negedge clk);
				stream_bus.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		stream_bus.valid      <= 1'b1;
		stream_bus.data_byte  <= b;
		stream_bus.final_byte <= last;
		do @(posedge clk); while (!stream_bus.ready);
		parse_byte(b, last, hit, st);
		if (hit)
			pending_status.push_back(st);
		sent_bytes++;
	endtask

	task automatic send_stream();
		int i;
		for (i = 0; i < pkt.size(); i++)
			send_byte(pkt[i], i == pkt.size() - 1);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_WIDTH)
			pm_width = value;
		else
			pm_height = value;
	endtask

	// hold valid low and wait out every status word still in flight
	task automatic drain();
		int waited;
		@(negedge clk);
		stream_bus.valid <= 1'b0;
		burst_left = 0;
		waited = 0;
		while (pending_status.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (pending_status.size() != 0) begin
			$error("%0d status words never arrived", pending_status.size());
			error_count++;
			pending_status.delete();
		end
	endtask

	task automatic add_marker(input logic [7:0] m);
		int fills;
		fills = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		pkt.push_back(MK_FILL);
		repeat (fills) pkt.push_back(MK_FILL);
		pkt.push_back(m);
	endtask

	task automatic add_misc_segment();
		logic [7:0]  m;
		logic [15:0] len;
		case ($urandom_range(0, 7))
			0:       m = MK_DHT;
			1:       m = MK_DAC;
			2:       m = MK_JPG;
			3:       m = MK_DQT;
			4:       m = MK_DRI;
			5:       m = MK_COM;
			6:       m = 8'($urandom_range(2, 8'hbf));
			default: m = MK_APP0 + 8'($urandom_range(0, 15));
		endcase
		add_marker(m);
		if ($urandom_range(0, 23) == 0) begin
			len = 16'($urandom_range(0, 1));
			pkt.push_back(len[15:8]);
			pkt.push_back(len[7:0]);
		end else begin
			if ($urandom_range(0, 31) == 0)
				len = 16'($urandom_range(256, 320));
			else
				len = 16'($urandom_range(2, 10));
			pkt.push_back(len[15:8]);
			pkt.push_back(len[7:0]);
			repeat (len - 16'd2) pkt.push_back(8'($urandom));
		end
	endtask

	task automatic add_frame(input bit good);
		logic [7:0]  m;
		logic [15:0] len;
		logic [7:0]  fld[9];
		int          k;
		m = MK_SOF3;
		if ($urandom_range(0, 7) == 0) begin
			do m = MK_SOF0 + 8'($urandom_range(0, 15));
			while (!sof_code(m) || m == MK_SOF3);
		end
		len = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(2, 14)) : FRAME_LEN;
		fld = '{PRECISION, pm_height[15:8], pm_height[7:0], pm_width[15:8], pm_width[7:0],
			NUM_COMP, 8'($urandom), SAMPLING, QUANT_TABLE};
		if (!good) begin
			k = $urandom_range(0, 8);
			fld[k] = fld[k] ^ 8'($urandom_range(1, 255));
		end
		add_marker(m);
		pkt.push_back(len[15:8]);
		pkt.push_back(len[7:0]);
		for (k = 0; k < len - 2; k++)
			pkt.push_back(k < 9 ? fld[k] : 8'($urandom));
	endtask

	task automatic build_stream();
		int kind;
		int nseg;
		int frame_at;
		int i;
		int cut;
		pkt.delete();
		kind = $urandom_range(0, 19);
		if (kind < 3) begin
			// noise, sometimes behind a valid start marker
			if ($urandom_range(0, 1)) begin
				pkt.push_back(MK_FILL);
				pkt.push_back(MK_SOI);
			end
			repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
		end else begin
			pkt.push_back(MK_FILL);
			pkt.push_back(MK_SOI);
			nseg = $urandom_range(0, 3);
			frame_at = ($urandom_range(0, 7) == 0) ? -1 : $urandom_range(0, nseg);
			for (i = 0; i <= nseg; i++) begin
				if (i == frame_at)
					add_frame($urandom_range(0, 3) != 0);
				else
					add_misc_segment();
			end
			if ($urandom_range(0, 15) == 0)
				add_frame(1'b1);
			add_marker(($urandom_range(0, 7) == 0) ? MK_EOI : MK_SOS);
			repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom));
			if (kind < 6) begin
				repeat ($urandom_range(1, 2)) pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
			end else if ($urandom_range(0, 5) == 0) begin
				cut = $urandom_range(1, pkt.size());
				while (pkt.size() > cut)
					void'(pkt.pop_back());
			end
		end
	endtask

	task automatic test_short_stream();
		pkt = '{MK_FILL, MK_SOI};
		send_stream();
	endtask

	task automatic test_bad_marker();
		// decided before the last byte: drop the tail
		pkt = '{MK_FILL, MK_SOI, MK_FILL, MK_RST0, 8'h55};
		send_stream();
	endtask

	task automatic test_end_of_image();
		pkt = '{MK_FILL, MK_SOI, MK_FILL, MK_EOI};
		send_stream();
	endtask

	task automatic test_short_length();
		pkt = '{MK_FILL, MK_SOI, MK_FILL, MK_APP0, 8'h00, 8'h01};
		send_stream();
	endtask

	task automatic test_scan_without_frame();
		pkt = '{MK_FILL, MK_SOI, MK_FILL, MK_SOS};
		send_stream();
	endtask

	task automatic test_truncated_frame();
		// a faulty frame header cut short reports truncation
		pkt = '{MK_FILL, MK_SOI, MK_FILL, MK_SOF0, 8'h00, 8'h0b, PRECISION};
		send_stream();
	endtask

	task automatic test_random_streams(input logic [15:0] w, input logic [15:0] h,
			input int n);
		int target;
		drain();
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		target = sent_bytes + n;
		while (sent_bytes < target) begin
			idle_on = ($urandom_range(0, 3) != 0);
			build_stream();
			send_stream();
		end
	endtask

	initial begin
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = CFG_WIDTH;
		cfg_data              = '0;
		stream_bus.valid      = 1'b0;
		stream_bus.data_byte  = '0;
		stream_bus.final_byte = 1'b0;
		result_bus.ready      = 1'b0;
		rx_mode               = 0;
		rx_left               = 0;
		burst_left            = 0;
		idle_on               = 1'b1;
		sent_bytes            = 0;
		error_count           = 0;
		pm_width              = '0;
		pm_height             = '0;
		clear_parser();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(CFG_WIDTH, 16'd0);
		write_reg(CFG_HEIGHT, 16'd0);
		test_short_stream();
		test_bad_marker();
		test_end_of_image();
		test_short_length();
		test_scan_without_frame();
		test_truncated_frame();

		test_random_streams(16'h0000, 16'h0000, 185);
		test_random_streams(16'hffff, 16'hffff, 185);
		test_random_streams(16'h0000, 16'hffff, 185);
		test_random_streams(16'hffff, 16'h0000, 185);
		test_random_streams(16'($urandom), 16'($urandom), 185);
		test_random_streams(16'($urandom_range(1, 255)), 16'($urandom), 185);
		test_random_streams(16'($urandom), 16'($urandom_range(1, 255)), 190);
		drain();

		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
